// File: sv/afid_pkg.sv
// ----------------------------------------------------------------------------
// afid_pkg
// Shared types, constants and slot map for the audio frame interleaver
// with its optional 48 kHz to 44.1 kHz decimator.
// ----------------------------------------------------------------------------
package afid_pkg;

	// channel and slot geometry
	localparam int NCHAN = 6;
	localparam int NSLOT = 6;

	// configuration port
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DECIMATE_ENABLE = 1'b1;

	// channel modes
	localparam logic [3:0] MODE_MONO          = 4'd0;
	localparam logic [3:0] MODE_STEREO        = 4'd1;
	localparam logic [3:0] MODE_3F            = 4'd2;
	localparam logic [3:0] MODE_2F2R          = 4'd3;
	localparam logic [3:0] MODE_3F2R          = 4'd4;
	localparam logic [3:0] MODE_MONO_LFE      = 4'd5;
	localparam logic [3:0] MODE_STEREO_LFE    = 4'd6;
	localparam logic [3:0] MODE_3F_LFE        = 4'd7;
	localparam logic [3:0] MODE_2F2R_LFE      = 4'd8;
	localparam logic [3:0] MODE_3F2R_LFE      = 4'd9;
	localparam logic [3:0] MODE_RESET         = MODE_STEREO;

	// biased float window around the 384.0 pattern
	localparam logic signed [31:0] PAT_HIGH = 32'sh43c0_7fff;
	localparam logic signed [31:0] PAT_LOW  = 32'sh43bf_8000;
	localparam logic signed [31:0] PAT_BIAS = 32'sh43c0_0000;
	localparam logic signed [15:0] PCM_MAX  = 16'sh7fff;
	localparam logic signed [15:0] PCM_MIN  = -16'sh8000;

	// decimator
	localparam int PHASE_WRAP = 147;
	localparam int SKIP_EVERY = 12;
	localparam int PHASE_W    = $clog2(PHASE_WRAP);
	localparam int SUBPH_W    = $clog2(SKIP_EVERY);
	localparam int BLOCK_LEN  = 256;
	localparam int BLOCK_W    = $clog2(BLOCK_LEN);

	// slot source code, value SRC_ZERO (7) means zero fill
	localparam logic [2:0] SRC_ZERO = 3'd7;

	typedef logic [NCHAN-1:0][31:0]      word_vec_t;
	typedef logic signed [15:0]          pcm_t;
	typedef pcm_t [NCHAN-1:0]            pcm_vec_t;
	typedef pcm_t [NSLOT-1:0]            slot_vec_t;
	typedef logic [NSLOT-1:0][2:0]       src_map_t;

	// output slot routing per channel mode; undefined modes act as stereo
	function automatic src_map_t slot_map(input logic [3:0] mode);
		src_map_t m;
		m = '{default: SRC_ZERO};
		case (mode)
			MODE_MONO: begin
				m[4] = 3'd0;
			end
			MODE_3F: begin
				m[0] = 3'd0; m[1] = 3'd2; m[4] = 3'd1;
			end
			MODE_2F2R: begin
				m[0] = 3'd0; m[1] = 3'd1; m[2] = 3'd2; m[3] = 3'd3;
			end
			MODE_3F2R: begin
				m[0] = 3'd0; m[1] = 3'd2; m[2] = 3'd3; m[3] = 3'd4; m[4] = 3'd1;
			end
			MODE_MONO_LFE: begin
				m[4] = 3'd1; m[5] = 3'd0;
			end
			MODE_STEREO_LFE: begin
				m[0] = 3'd1; m[1] = 3'd2; m[5] = 3'd0;
			end
			MODE_3F_LFE: begin
				m[0] = 3'd1; m[1] = 3'd3; m[4] = 3'd2; m[5] = 3'd0;
			end
			MODE_2F2R_LFE: begin
				m[0] = 3'd1; m[1] = 3'd2; m[2] = 3'd3; m[3] = 3'd4; m[5] = 3'd0;
			end
			MODE_3F2R_LFE: begin
				m[0] = 3'd1; m[1] = 3'd3; m[2] = 3'd4; m[3] = 3'd5;
				m[4] = 3'd2; m[5] = 3'd0;
			end
			default: begin
				m[0] = 3'd0; m[1] = 3'd1;
			end
		endcase
		return m;
	endfunction

	// number of leading slots in use per channel mode
	function automatic logic [2:0] slot_cnt(input logic [3:0] mode);
		logic [2:0] c;
		case (mode) inside
			MODE_MONO, MODE_3F, MODE_3F2R:           c = 3'd5;
			MODE_2F2R:                               c = 3'd4;
			[MODE_MONO_LFE:MODE_3F2R_LFE]:           c = 3'd6;
			default:                                 c = 3'd2;
		endcase
		return c;
	endfunction

endpackage

// File: sv/afid_decim.sv
// ----------------------------------------------------------------------------
// afid_decim
// Drop-pattern generator: decides per accepted input whether it gives a
// result, with phase wrap at 147, extra skip on multiples of 12, and skip
// cancel at each block boundary.
// ----------------------------------------------------------------------------
module afid_decim (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic decim_en,
	output logic keep
);

	logic [afid_pkg::PHASE_W-1:0] phase_q;
	logic [afid_pkg::SUBPH_W-1:0] subph_q;
	logic                         skip_q;
	logic [afid_pkg::BLOCK_W-1:0] blk_pos_q;

	logic phase_last;
	logic subph_last;
	logic blk_last;

	assign keep       = !(decim_en && skip_q);
	assign phase_last = phase_q == afid_pkg::PHASE_W'(afid_pkg::PHASE_WRAP - 1);
	assign subph_last = subph_q == afid_pkg::SUBPH_W'(afid_pkg::SKIP_EVERY - 1);
	assign blk_last   = blk_pos_q == afid_pkg::BLOCK_W'(afid_pkg::BLOCK_LEN - 1);

	// phase, phase mod 12, skip flag and block position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			subph_q   <= '0;
			skip_q    <= 1'b0;
			blk_pos_q <= '0;
		end else if (accept) begin
			if (decim_en && !skip_q) begin
				if (phase_last) begin
					phase_q <= '0;
					subph_q <= '0;
				end else begin
					phase_q <= phase_q + 1'b1;
					subph_q <= subph_last ? '0 : subph_q + 1'b1;
				end
			end
			if (blk_last) begin
				skip_q    <= 1'b0;
				blk_pos_q <= '0;
			end else begin
				blk_pos_q <= blk_pos_q + 1'b1;
				if (!decim_en || skip_q)
					skip_q <= 1'b0;
				else
					skip_q <= subph_q == '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < afid_pkg::PHASE_W'(afid_pkg::PHASE_WRAP))
		else $error("phase out of range");
	a_subph_range: assert property (@(posedge clk) disable iff (!arst_n)
		subph_q < afid_pkg::SUBPH_W'(afid_pkg::SKIP_EVERY))
		else $error("sub-phase out of range");
	a_skip_clear_off: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !decim_en) |=> !skip_q)
		else $error("skip left pending with decimation off");
	a_no_double_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !keep) |=> !skip_q)
		else $error("two drops in a row");
`endif

endmodule

// File: sv/afid_conv.sv
// ----------------------------------------------------------------------------
// afid_conv
// Biased float to PCM16 conversion of all channel words: subtract the
// 384.0 pattern and saturate to signed 16 bits.
// ----------------------------------------------------------------------------
module afid_conv (
	input  afid_pkg::word_vec_t words,
	output afid_pkg::pcm_vec_t  pcm
);

	// one saturating converter per channel
	always_comb begin
		logic signed [31:0] w;
		logic signed [31:0] d;
		for (int i = 0; i < afid_pkg::NCHAN; i++) begin
			w = $signed(words[i]);
			d = w - afid_pkg::PAT_BIAS;
			if (w > afid_pkg::PAT_HIGH)
				pcm[i] = afid_pkg::PCM_MAX;
			else if (w < afid_pkg::PAT_LOW)
				pcm[i] = afid_pkg::PCM_MIN;
			else
				pcm[i] = d[15:0];
		end
	end

endmodule

// File: sv/afid_route.sv
// ----------------------------------------------------------------------------
// afid_route
// Speaker slot routing: places converted channels into slots by channel
// mode and zero-fills unused slots.
// ----------------------------------------------------------------------------
module afid_route (
	input  logic [3:0]          mode,
	input  afid_pkg::pcm_vec_t  pcm,
	output afid_pkg::slot_vec_t slots,
	output logic [2:0]          count
);

	afid_pkg::src_map_t map;

	assign map   = afid_pkg::slot_map(mode);
	assign count = afid_pkg::slot_cnt(mode);

	// per-slot source select
	always_comb begin
		for (int j = 0; j < afid_pkg::NSLOT; j++) begin
			if (map[j] == afid_pkg::SRC_ZERO)
				slots[j] = '0;
			else
				slots[j] = pcm[map[j]];
		end
	end

endmodule

// File: sv/audio_frame_interleave_decimate.sv
// ----------------------------------------------------------------------------
// audio_frame_interleave_decimate
// Six-channel biased float to PCM16 interleaver with optional
// 48 kHz to 44.1 kHz decimation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with chan0_word..chan5_word, one
//   sample time per transaction. Output channel: out_valid / out_stall with
//   slot0..slot5 and slot_count, one transaction per kept input.
//   Config port: cfg_write, cfg_index (0 channel_mode, 1 decimate_enable),
//   cfg_data; write only while the block is idle.
//   Path: a kept input goes through the input register, then the result
//   register, before it shows on out_valid.
//   Throughput: one input per cycle while in_stall is low; the decimator
//   drops 13 of every 160 inputs when enabled, and a dropped input simply
//   never reaches the output. The rate is set by the result register,
//   which frees every cycle while out_stall is low.
//   Reset: channel_mode stereo, decimation off, phase, skip flag and block
//   position cleared, both stages empty.
//   Stall: a stalled result holds; inputs are taken until a kept one
//   fills the input register, then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module audio_frame_interleave_decimate (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_write,
	input  logic [afid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [afid_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       chan0_word,
	input  logic [31:0]                       chan1_word,
	input  logic [31:0]                       chan2_word,
	input  logic [31:0]                       chan3_word,
	input  logic [31:0]                       chan4_word,
	input  logic [31:0]                       chan5_word,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                slot0,
	output logic signed [15:0]                slot1,
	output logic signed [15:0]                slot2,
	output logic signed [15:0]                slot3,
	output logic signed [15:0]                slot4,
	output logic signed [15:0]                slot5,
	output logic [2:0]                        slot_count
);

	logic [3:0] mode_q;
	logic       decim_en_q;

	logic                 in_accept;
	logic                 keep;
	logic                 valid_s1;
	afid_pkg::word_vec_t  words_s1;
	afid_pkg::pcm_vec_t   pcm;
	afid_pkg::slot_vec_t  slots;
	logic [2:0]           count;
	logic                 valid_s2;
	afid_pkg::slot_vec_t  slots_s2;
	logic [2:0]           count_s2;
	logic                 load_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= afid_pkg::MODE_RESET;
			decim_en_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				afid_pkg::REG_CHANNEL_MODE:    mode_q     <= cfg_data;
				afid_pkg::REG_DECIMATE_ENABLE: decim_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage advance
	assign load_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !load_s2;
	assign in_accept = in_valid && !in_stall;

	afid_decim u_decim (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_accept),
		.decim_en (decim_en_q),
		.keep     (keep)
	);

	// input register, only kept inputs become valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_accept)
			valid_s1 <= keep;
		else if (load_s2)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			words_s1 <= {chan5_word, chan4_word, chan3_word,
				chan2_word, chan1_word, chan0_word};
	end

	afid_conv u_conv (
		.words (words_s1),
		.pcm   (pcm)
	);

	afid_route u_route (
		.mode  (mode_q),
		.pcm   (pcm),
		.slots (slots),
		.count (count)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (load_s2)
			valid_s2 <= 1'b1;
		else if (!out_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			slots_s2 <= slots;
			count_s2 <= count;
		end
	end

	assign out_valid  = valid_s2;
	assign slot0      = slots_s2[0];
	assign slot1      = slots_s2[1];
	assign slot2      = slots_s2[2];
	assign slot3      = slots_s2[3];
	assign slot4      = slots_s2[4];
	assign slot5      = slots_s2[5];
	assign slot_count = count_s2;

`ifndef SYNTHESIS
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |-> in_stall)
		else $error("input taken with both stages blocked");
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result without a staged input");
	a_drop_no_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !keep) |=> !valid_s1)
		else $error("dropped input entered the pipeline");
`endif

endmodule
